FILE: rtl/core/slipcrc_pkg.sv
// Shared types, codes and the byte-wide CRC-32 step for the SLIP deframer.
// No dependencies; imported by the deframer core, the output buffer and the top level.
package slipcrc_pkg;

  // SLIP framing bytes
  localparam logic [7:0] SlipEnd    = 8'hC0;
  localparam logic [7:0] SlipEsc    = 8'hDB;
  localparam logic [7:0] SlipEscEnd = 8'hDC;
  localparam logic [7:0] SlipEscEsc = 8'hDD;

  // reflected IEEE polynomial
  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  // configuration port
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 32;
  localparam logic [CfgIdxWidth-1:0] RegCrcSeed = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegMaxLen  = 2'd1;

  localparam logic [15:0] MaxLenReset = 16'hFFFF;

  typedef enum logic {
    KindData   = 1'b0,
    KindStatus = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusCrcErr   = 2'd1,
    StatusProtoErr = 2'd2,
    StatusTooLong  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    status_e     status;
    logic [15:0] frame_len;
  } res_beat_t;

  // One byte through the zlib-style CRC-32: complement in, eight shift steps, complement out.
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return ~c;
  endfunction

endpackage

FILE: rtl/core/slipcrc_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Depends on nothing; the payload type comes from the instantiating module.
interface slipcrc_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/slipcrc_deframe.sv
// SLIP unescape, four-byte trailer delay, running CRC-32 and frame status.
// Depends on slipcrc_pkg. Holds the configuration registers.
module slipcrc_deframe #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [slipcrc_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [slipcrc_pkg::CfgDataWidth-1:0]     cfg_data_i,
  input  logic                                     acc_i,
  input  logic [7:0]                               rx_byte_i,
  output logic                                     res_valid_o,
  output slipcrc_pkg::res_beat_t                   res_o
);
  import slipcrc_pkg::*;

  localparam int unsigned CmpWidth = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic [31:0]            crc_seed_q;
  logic [15:0]            max_len_q;
  logic [31:0]            crc_q, crc_d;
  logic [3:0][7:0]        tail_q, tail_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   esc_q, esc_d;
  logic                   discard_q, discard_d;

  logic                   is_end;
  logic                   do_push;
  logic [7:0]             push_val;
  logic                   restart;
  logic                   at_limit;
  logic                   have_trailer;
  logic [COUNT_WIDTH-1:0] payload_len;

  assign is_end       = (rx_byte_i == SlipEnd);
  assign have_trailer = (cnt_q >= COUNT_WIDTH'(4));
  assign at_limit     = (CmpWidth'(cnt_q) == CmpWidth'(max_len_q)) || (&cnt_q);
  assign payload_len  = cnt_q - COUNT_WIDTH'(4);

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    do_push     = 1'b0;
    push_val    = rx_byte_i;
    restart     = 1'b0;
    esc_d       = esc_q;
    discard_d   = discard_q;
    crc_d       = crc_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;

    if (acc_i) begin
      if (discard_q) begin
        restart = is_end;
      end else if (is_end) begin
        res_valid_o = 1'b1;
        res_o.kind  = KindStatus;
        if (!have_trailer) begin
          res_o.status = StatusProtoErr;
        end else if ({tail_q[0], tail_q[1], tail_q[2], tail_q[3]} == crc_q) begin
          res_o.status    = StatusOk;
          res_o.frame_len = 16'(payload_len);
        end else begin
          res_o.status = StatusCrcErr;
        end
        restart = 1'b1;
      end else if (at_limit) begin
        discard_d    = 1'b1;
        res_valid_o  = 1'b1;
        res_o.kind   = KindStatus;
        res_o.status = StatusTooLong;
      end else if (esc_q) begin
        esc_d = 1'b0;
        if (rx_byte_i == SlipEscEsc) begin
          do_push  = 1'b1;
          push_val = SlipEsc;
        end else if (rx_byte_i == SlipEscEnd) begin
          do_push  = 1'b1;
          push_val = SlipEnd;
        end else begin
          discard_d    = 1'b1;
          res_valid_o  = 1'b1;
          res_o.kind   = KindStatus;
          res_o.status = StatusProtoErr;
        end
      end else if (rx_byte_i == SlipEsc) begin
        esc_d = 1'b1;
      end else begin
        do_push = 1'b1;
      end
    end

    // the oldest byte leaves the delay once four are held
    if (do_push) begin
      if (have_trailer) begin
        crc_d           = crc32_byte(crc_q, tail_q[0]);
        res_valid_o     = 1'b1;
        res_o.kind      = KindData;
        res_o.data_byte = tail_q[0];
        res_o.status    = StatusOk;
      end
      tail_d = {push_val, tail_q[3], tail_q[2], tail_q[1]};
      cnt_d  = cnt_q + COUNT_WIDTH'(1);
    end

    if (restart) begin
      crc_d     = crc_seed_q;
      tail_d    = '0;
      cnt_d     = '0;
      esc_d     = 1'b0;
      discard_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_seed_q <= '0;
      max_len_q  <= MaxLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCrcSeed: crc_seed_q <= cfg_data_i;
        RegMaxLen:  max_len_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      esc_q     <= 1'b0;
      discard_q <= 1'b0;
    end else begin
      crc_q     <= crc_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
      esc_q     <= esc_d;
      discard_q <= discard_d;
    end
  end

  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    discard_q |-> !res_valid_o)
    else $error("output while discarding");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && is_end) |=> (cnt_q == '0) && !discard_q && !esc_q)
    else $error("END did not restart the frame");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KindData) |-> (res_o.status == StatusOk) &&
      (res_o.frame_len == '0) && have_trailer)
    else $error("malformed data beat");

  a_len_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != StatusOk) |-> (res_o.frame_len == '0))
    else $error("length on a failed frame");

endmodule

FILE: rtl/core/slipcrc_skid.sv
// Two-entry output buffer between the deframer core and the result channel.
// Depends on slipcrc_pkg for the result beat type.
module slipcrc_skid (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  slipcrc_pkg::res_beat_t push_data_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  logic                   pop_ready_i,
  output slipcrc_pkg::res_beat_t data_o
);
  import slipcrc_pkg::*;

  res_beat_t  slot0_q, slot1_q;
  logic [1:0] count_q, count_d;
  logic       pop;
  logic       load0;
  logic       load1;

  assign valid_o = (count_q != 2'd0);
  assign ready_o = (count_q != 2'd2);
  assign data_o  = slot0_q;
  assign pop     = valid_o && pop_ready_i;

  assign load0 = (count_q == 2'd0 && push_i) || (pop && count_q == 2'd1 && push_i) ||
                 (pop && count_q == 2'd2);
  assign load1 = push_i && !pop && count_q == 2'd1;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load0) begin
      slot0_q <= (count_q == 2'd2) ? slot1_q : push_data_i;
    end
    if (load1) begin
      slot1_q <= push_data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("buffer count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("push into full buffer");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i && count_q == 2'd1) |=> !valid_o)
    else $error("buffer did not drain");

endmodule

FILE: rtl/core/slip_crc32_frame_decoder.sv
// SLIP deframer with CRC-32 trailer check: one raw line byte per beat in,
// payload bytes and frame status beats out. A result beat is registered in the output
// buffer before it is valid on res. Throughput: one byte per cycle while that buffer is
// not full; the core decodes, updates the CRC and classifies in the cycle a byte is
// accepted, and the two-entry buffer keeps rx ready while one result waits. Reset (async,
// active low) clears frame state and the buffer; crc_seed resets to 0 and max_len to 65535.
module slip_crc32_frame_decoder #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [slipcrc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [slipcrc_pkg::CfgDataWidth-1:0] cfg_data_i,
  slipcrc_stream_if.sink                       rx_i,
  slipcrc_stream_if.source                     res_o
);
  import slipcrc_pkg::*;

  logic      acc;
  logic      core_valid;
  res_beat_t core_res;
  logic      buf_ready;
  res_beat_t buf_data;

  assign rx_i.ready = buf_ready;
  assign acc        = rx_i.valid && buf_ready;

  slipcrc_deframe #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_deframe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (acc),
    .rx_byte_i  (rx_i.payload.rx_byte),
    .res_valid_o(core_valid),
    .res_o      (core_res)
  );

  slipcrc_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (core_valid),
    .push_data_i(core_res),
    .ready_o    (buf_ready),
    .valid_o    (res_o.valid),
    .pop_ready_i(res_o.ready),
    .data_o     (buf_data)
  );

  assign res_o.payload = buf_data;

endmodule
